/* rtl/core/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way sorted merge: lane geometry,
// command and status codes, the lane pointer update bundle and the position step.
// ----------------------------------------------------------------------------
package kwm_pkg;

   // lane geometry
   localparam int LANES      = 8;
   localparam int LANE_DEPTH = 256;
   localparam int LANE_W     = 3;
   localparam int POS_W      = $clog2(LANE_DEPTH);
   localparam int CNT_W      = $clog2(LANE_DEPTH + 1);
   localparam int ADDR_W     = LANE_W + POS_W;
   localparam int STORE_DEPTH = LANES * LANE_DEPTH;

   // payload and register widths
   localparam int DATA_W = 32;
   localparam int CFG_W  = 4;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // reset value of the lanes in use register
   localparam logic [CFG_W-1:0] LANES_RESET = CFG_W'(LANES);

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } kwm_status_type;

   // pointer update request towards the lane file
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [LANE_W-1:0] lane;
   } kwm_upd_type;

   // circular position step within one lane
   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] res;
      if (pos == POS_W'(LANE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = pos + 1'b1;
      end
      return res;
   endfunction

endpackage

/* rtl/core/kwm_ram.sv */
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/kwm_lane_file.sv */
// ----------------------------------------------------------------------------
// kwm_lane_file
// Per-lane head position, tail position and fill count, with one read lane
// and one push or pop update per cycle.
// ----------------------------------------------------------------------------
module kwm_lane_file (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [kwm_pkg::LANE_W-1:0] rd_lane,
   input  kwm_pkg::kwm_upd_type       upd,
   output logic [kwm_pkg::POS_W-1:0]  rd_head,
   output logic [kwm_pkg::POS_W-1:0]  rd_tail,
   output logic [kwm_pkg::CNT_W-1:0]  rd_fill
);
   import kwm_pkg::*;

   logic [POS_W-1:0] head_ff [LANES];
   logic [POS_W-1:0] head_in [LANES];
   logic [POS_W-1:0] tail_ff [LANES];
   logic [POS_W-1:0] tail_in [LANES];
   logic [CNT_W-1:0] fill_ff [LANES];
   logic [CNT_W-1:0] fill_in [LANES];

   // read of the selected lane
   assign rd_head = head_ff[rd_lane];
   assign rd_tail = tail_ff[rd_lane];
   assign rd_fill = fill_ff[rd_lane];

   // push moves the tail, pop moves the head
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         fill_in[i] = fill_ff[i];
         if (upd.lane == LANE_W'(i)) begin
            if (upd.push) begin
               tail_in[i] = next_pos(tail_ff[i]);
               fill_in[i] = fill_ff[i] + 1'b1;
            end else if (upd.pop) begin
               head_in[i] = next_pos(head_ff[i]);
               fill_in[i] = fill_ff[i] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < LANES; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   // never both operations at once
   a_one_update : assert property (@(posedge clock) disable iff (reset)
      !(upd.push && upd.pop))
      else $error("lane file push and pop in the same cycle");

   // counts stay within the lane depth
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      rd_fill <= CNT_W'(LANE_DEPTH))
      else $error("lane fill count beyond depth");

   // tail runs ahead of head by exactly the fill count
   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      POS_W'(rd_tail - rd_head) == POS_W'(rd_fill))
      else $error("lane pointers disagree with fill count");

endmodule

/* rtl/core/k_way_sorted_merge.sv */
// Sequence: a push goes through the push state and the result state, a pop
// through the scan state over the lanes in use, the drain and the result state.
// A new request is taken only back in idle, so one request is handled at a
// time; the scan makes one head read per cycle on the single store read port
// feeding the single signed comparator. Output backpressure adds its wait.
// Reset: pointers and counts clear, lanes in use returns to 8, store content
// is left as it is and needs no clearing pass.
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// K-way merge of sorted lists kept in per-lane FIFOs: push appends to a lane,
// pop scans the lane heads and removes the smallest, lowest lane on ties.
// ----------------------------------------------------------------------------
module k_way_sorted_merge (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [kwm_pkg::LANE_W-1:0] req_lane,
   input  logic signed [kwm_pkg::DATA_W-1:0] req_in_value,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [kwm_pkg::DATA_W-1:0] rsp_out_value,
   output logic [kwm_pkg::LANE_W-1:0] rsp_out_lane,
   output logic [1:0]                 rsp_status,
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [kwm_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [kwm_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [kwm_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import kwm_pkg::*;

   localparam logic REG_LANES = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type                state_ff, state_in;
   logic [CFG_W-1:0]         lanes_ff, lanes_in;
   logic                     cmd_ff, cmd_in;
   logic [LANE_W-1:0]        lane_ff, lane_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [LANE_W-1:0]        n_last_ff, n_last_in;
   logic [LANE_W-1:0]        iss_ff, iss_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [LANE_W-1:0]        cmp_lane_ff, cmp_lane_in;
   logic                     found_ff, found_in;
   logic [LANE_W-1:0]        pick_ff, pick_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   kwm_status_type           stat_ff, stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LANE_W-1:0]        rsp_lane_ff, rsp_lane_in;
   kwm_status_type           rsp_stat_ff, rsp_stat_in;

   logic                     req_accept;
   logic                     csr_write;
   logic                     rsp_load;
   logic [LANE_W-1:0]        n_last;
   logic [LANE_W-1:0]        lf_lane;
   kwm_upd_type              upd;
   logic [POS_W-1:0]         lf_head;
   logic [POS_W-1:0]         lf_tail;
   logic [CNT_W-1:0]         lf_fill;
   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic signed [DATA_W-1:0] ram_rd_data;

   // handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   // register read back
   assign csr_prdata = (csr_paddr[2] == REG_LANES) ? CSR_DW'(lanes_ff) : '0;

   // last lane taking part, register clamped to 1..LANES
   always_comb begin
      if (lanes_ff == '0) begin
         n_last = '0;
      end else if (lanes_ff > CFG_W'(LANES)) begin
         n_last = LANE_W'(LANES - 1);
      end else begin
         n_last = LANE_W'(lanes_ff - 1'b1);
      end
   end

   // lane file read select
   always_comb begin
      unique case (state_ff)
         ST_PUSH:   lf_lane = lane_ff;
         ST_RESULT: lf_lane = pick_ff;
         default:   lf_lane = iss_ff;
      endcase
   end

   kwm_lane_file u_lane_file (
      .clock   (clock),
      .reset   (reset),
      .rd_lane (lf_lane),
      .upd     (upd),
      .rd_head (lf_head),
      .rd_tail (lf_tail),
      .rd_fill (lf_fill)
   );

   // store access: push writes at the tail, scan reads the heads
   assign ram_wr_addr = {lane_ff, lf_tail};
   assign ram_rd_addr = {iss_ff, lf_head};

   kwm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      lanes_in     = lanes_ff;
      cmd_in       = cmd_ff;
      lane_in      = lane_ff;
      value_in     = value_ff;
      n_last_in    = n_last_ff;
      iss_in       = iss_ff;
      cmp_vld_in   = 1'b0;
      cmp_lane_in  = cmp_lane_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_lane_in  = rsp_lane_ff;
      rsp_stat_in  = rsp_stat_ff;
      ram_wr_en    = 1'b0;
      upd          = '{push: 1'b0, pop: 1'b0, lane: '0};

      // register write
      if (csr_write && (csr_paddr[2] == REG_LANES)) begin
         lanes_in = csr_pwdata[CFG_W-1:0];
      end

      // shared comparator: head read issued last cycle
      if (cmp_vld_ff && (!found_ff || (ram_rd_data < best_ff))) begin
         found_in = 1'b1;
         pick_in  = cmp_lane_ff;
         best_in  = ram_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_cmd;
               lane_in   = req_lane;
               value_in  = req_in_value;
               n_last_in = n_last;
               iss_in    = '0;
               found_in  = 1'b0;
               state_in  = (req_cmd == CMD_POP) ? ST_SCAN : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (lane_ff > n_last_ff) begin
               stat_in = STAT_RANGE;
            end else if (lf_fill >= CNT_W'(LANE_DEPTH)) begin
               stat_in = STAT_FULL;
            end else begin
               stat_in   = STAT_OK;
               ram_wr_en = 1'b1;
               upd       = '{push: 1'b1, pop: 1'b0, lane: lane_ff};
            end
            state_in = ST_RESULT;
         end
         ST_SCAN: begin
            cmp_vld_in  = (lf_fill != '0);
            cmp_lane_in = iss_ff;
            iss_in      = iss_ff + 1'b1;
            if (iss_ff == n_last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_lane_in  = '0;
               rsp_stat_in  = stat_ff;
               if (cmd_ff == CMD_POP) begin
                  if (found_ff) begin
                     rsp_value_in = best_ff;
                     rsp_lane_in  = pick_ff;
                     rsp_stat_in  = STAT_OK;
                     upd          = '{push: 1'b0, pop: 1'b1, lane: pick_ff};
                  end else begin
                     rsp_stat_in = STAT_EMPTY;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lanes_ff     <= LANES_RESET;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lanes_ff     <= lanes_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         lane_ff      <= lane_in;
         value_ff     <= value_in;
         n_last_ff    <= n_last_in;
         iss_ff       <= iss_in;
         cmp_lane_ff  <= cmp_lane_in;
         pick_ff      <= pick_in;
         best_ff      <= best_in;
         stat_ff      <= stat_in;
         rsp_value_ff <= rsp_value_in;
         rsp_lane_ff  <= rsp_lane_in;
         rsp_stat_ff  <= rsp_stat_in;
      end
   end

   // result channel
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_lane  = rsp_lane_ff;
   assign rsp_status    = rsp_stat_ff;

   // a pop only ever removes from a non-empty lane
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      upd.pop |-> (lf_fill != '0))
      else $error("pop removes from an empty lane");

   // a push only ever stores into a lane with room
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      upd.push |-> (lf_fill < CNT_W'(LANE_DEPTH)))
      else $error("push stores into a full lane");

   // the scan never issues past the last lane in use
   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_ff <= n_last_ff))
      else $error("scan index beyond lanes in use");

   // a picked lane is always one that took part in the scan
   a_pick_bound : assert property (@(posedge clock) disable iff (reset)
      (found_ff && (state_ff == ST_RESULT)) |-> (pick_ff <= n_last_ff))
      else $error("picked lane outside lanes in use");

   // a result load is followed by a valid result transfer slot
   a_load_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result load lost");

endmodule

/* bench/kwm_merge_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_checker
// Watches the request, result and register ports of the k-way sorted merge.
// It keeps its own copy of the lane FIFOs and of the lanes in use setting,
// works out the result of every request transfer, and compares each result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module kwm_merge_checker
   import kwm_pkg::*;
#(
   parameter logic [CSR_AW-1:0] LANES_ADDR = '0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [LANE_W-1:0]        req_lane,
   input  logic signed [DATA_W-1:0] req_in_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_out_value,
   input  logic [LANE_W-1:0]        rsp_out_lane,
   input  logic [1:0]               rsp_status,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   input  logic                     csr_pready,
   output int unsigned              error_count,
   output int unsigned              pending_count,
   output int unsigned              merged_count,
   output int unsigned              empty_count,
   output int unsigned              full_count,
   output int unsigned              range_count
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [LANE_W-1:0]        lane;
      kwm_status_type           status;
   } merge_result_t;

   // shadow lane FIFOs and lanes in use setting
   logic signed [DATA_W-1:0] lane_data [LANES][LANE_DEPTH];
   logic [POS_W-1:0]         lane_head [LANES];
   logic [POS_W-1:0]         lane_tail [LANES];
   int unsigned              lane_fill [LANES];
   logic [CFG_W-1:0]         lanes_cfg;

   // results still owed by the block, oldest first
   merge_result_t due_results [$];

   // one push or pop applied to the shadow lanes
   task automatic merge_step(input logic cmd, input logic [LANE_W-1:0] lane,
                             input logic signed [DATA_W-1:0] value,
                             output merge_result_t res);
      int                       n;
      int                       pick;
      bit                       found;
      logic signed [DATA_W-1:0] best;
      n = (lanes_cfg == '0) ? 1 : (int'(lanes_cfg) > LANES) ? LANES : int'(lanes_cfg);
      res.value  = '0;
      res.lane   = '0;
      res.status = STAT_OK;
      if (cmd == CMD_PUSH) begin
         if (int'(lane) >= n) begin
            res.status = STAT_RANGE;
            range_count++;
         end else if (lane_fill[lane] >= LANE_DEPTH) begin
            res.status = STAT_FULL;
            full_count++;
         end else begin
            lane_data[lane][lane_tail[lane]] = value;
            lane_tail[lane] = POS_W'((int'(lane_tail[lane]) + 1) % LANE_DEPTH);
            lane_fill[lane]++;
         end
      end else begin
         found = 1'b0;
         pick  = 0;
         best  = '0;
         // strict compare keeps the lowest lane on equal heads
         for (int i = 0; i < n; i++) begin
            if (lane_fill[i] != 0 && (!found || lane_data[i][lane_head[i]] < best)) begin
               found = 1'b1;
               pick  = i;
               best  = lane_data[i][lane_head[i]];
            end
         end
         if (!found) begin
            res.status = STAT_EMPTY;
            empty_count++;
         end else begin
            lane_head[pick] = POS_W'((int'(lane_head[pick]) + 1) % LANE_DEPTH);
            lane_fill[pick]--;
            res.value = best;
            res.lane  = LANE_W'(pick);
            merged_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      merge_result_t want;
      merge_result_t fresh;
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            lane_head[i] = '0;
            lane_tail[i] = '0;
            lane_fill[i] = 0;
         end
         lanes_cfg = LANES_RESET;
         due_results.delete();
         error_count   = 0;
         pending_count = 0;
         merged_count  = 0;
         empty_count   = 0;
         full_count    = 0;
         range_count   = 0;
      end else begin
         // register write
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LANES_ADDR) begin
            lanes_cfg = csr_pwdata[CFG_W-1:0];
         end
         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got value %0d lane %0d status %0d",
                        $time, rsp_out_value, rsp_out_lane, rsp_status);
               error_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               if (rsp_out_value !== want.value) begin
                  $display("%0t: value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_out_value);
                  error_count++;
               end
               if (rsp_out_lane !== want.lane) begin
                  $display("%0t: lane mismatch, expected %0d, got %0d",
                           $time, want.lane, rsp_out_lane);
                  error_count++;
               end
            end
         end
         // request transfer
         if (req_valid && !req_stall) begin
            merge_step(req_cmd, req_lane, req_in_value, fresh);
            due_results.push_back(fresh);
         end
         pending_count = due_results.size();
      end
   end

endmodule

/* bench/k_way_sorted_merge_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_tb
// Drives pushes and pops into the k-way sorted merge under several lanes in
// use settings: a directed opening on the edge cases, then sorted per-lane
// streams, random noise, a full lane and a long result hold-off. Checking is
// left to the merge checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_tb;
   import kwm_pkg::*;

   localparam int     HALF_PERIOD    = 5;
   localparam int     RESET_CYCLES   = 8;
   localparam int     ITEM_TARGET    = 1950;
   localparam int     FINAL_ITEMS    = 120;
   localparam int     LONG_HOLD      = 200;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     SETTLE_CYCLES  = 12;
   localparam int     DRAIN_CYCLES   = 24;
   localparam longint MAX_VALUE      = 64'sh7FFF_FFFF;
   localparam longint MIN_VALUE      = -MAX_VALUE - 1;

   // register map
   localparam logic [CSR_AW-1:0] LANES_ADDR = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] SPARE_ADDR = CSR_AW'(4);

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_cmd;
   logic [LANE_W-1:0]        req_lane;
   logic signed [DATA_W-1:0] req_in_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic [LANE_W-1:0]        rsp_out_lane;
   logic [1:0]               rsp_status;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_AW-1:0]        csr_paddr;
   logic [CSR_DW-1:0]        csr_pwdata;
   logic [CSR_DW-1:0]        csr_prdata;
   logic                     csr_pready;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned merged_count;
   int unsigned empty_count;
   int unsigned full_count;
   int unsigned range_count;

   int unsigned items_sent     = 0;
   int unsigned settings_done  = 0;
   int unsigned src_idle_pct   = 0;
   int unsigned sink_stall_pct = 0;
   int          lanes_now      = LANES;
   bit          hold_request   = 1'b0;
   bit          hold_done      = 1'b0;
   bit          fill_done      = 1'b0;
   int unsigned idle_cycles;

   k_way_sorted_merge dut (.*);

   kwm_merge_checker #(.LANES_ADDR(LANES_ADDR)) u_checker (.*);

   // 10 ns clock
   always #HALF_PERIOD clock = ~clock;

   // idling share for one phase
   function automatic int unsigned pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   // lanes in use setting, mostly legal, sometimes zero or above the lane count
   function automatic logic [CFG_W-1:0] random_setting();
      if ($urandom_range(0, 9) < 7) begin
         return CFG_W'($urandom_range(1, LANES));
      end else if ($urandom_range(0, 1) == 0) begin
         return '0;
      end else begin
         return CFG_W'($urandom_range(LANES + 1, (1 << CFG_W) - 1));
      end
   endfunction

   // one request transfer, with an optional gap before it
   task automatic send_item(input logic cmd, input logic [LANE_W-1:0] lane,
                            input logic signed [DATA_W-1:0] value);
      if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_lane     <= lane;
      req_in_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // let every outstanding result come back
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // setup then access phase
   task automatic write_reg(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // new lanes in use setting once the block is idle, junk in the unused bits
   task automatic set_lanes(input logic [CFG_W-1:0] setting);
      settle();
      write_reg(LANES_ADDR, CSR_DW'({$urandom(), setting}));
      lanes_now = (setting == '0) ? 1 : (int'(setting) > LANES) ? LANES : int'(setting);
      settings_done++;
   endtask

   // sorted stream per lane, interleaved, with a few early pops, then drained
   task automatic merge_phase(input int pushes);
      longint            tip [LANES];
      int unsigned       step_max;
      int                early_pops;
      logic [LANE_W-1:0] ln;
      case ($urandom_range(0, 3))
         0: step_max = 0;
         1: step_max = 2;
         2: step_max = 1000;
         default: step_max = 1 << 22;
      endcase
      for (int i = 0; i < LANES; i++) begin
         case ($urandom_range(0, 2))
            0: tip[i] = MIN_VALUE + longint'($urandom_range(0, 40));
            1: tip[i] = longint'($signed($urandom()));
            default: tip[i] = longint'($urandom_range(0, 20)) - 10;
         endcase
      end
      early_pops = 0;
      for (int k = 0; k < pushes; k++) begin
         // mostly lanes in use, now and then any lane
         if ($urandom_range(0, 9) == 0) begin
            ln = LANE_W'($urandom_range(0, LANES - 1));
         end else begin
            ln = LANE_W'($urandom_range(0, lanes_now - 1));
         end
         send_item(CMD_PUSH, ln, DATA_W'(tip[ln]));
         tip[ln] += longint'($urandom_range(0, step_max));
         if (tip[ln] > MAX_VALUE) begin
            tip[ln] = MAX_VALUE;
         end
         if ($urandom_range(0, 4) == 0) begin
            send_item(CMD_POP, LANE_W'($urandom()), DATA_W'($urandom()));
            early_pops++;
         end
      end
      repeat (pushes - early_pops + $urandom_range(1, 2)) begin
         send_item(CMD_POP, LANE_W'($urandom()), DATA_W'($urandom()));
      end
   endtask

   // result side stalls: random bursts, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      longint            fill_tip;
      logic [LANE_W-1:0] fill_lane;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = CMD_PUSH;
      req_lane     = '0;
      req_in_value = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pop straight after reset, all lanes in use
      send_item(CMD_POP, 3'd5, 32'sh1234_5678);
      // field extremes, a three-way tie on five and an all-ones value
      send_item(CMD_PUSH, 3'd0, 32'sh7FFF_FFFF);
      send_item(CMD_PUSH, 3'd7, 32'sh8000_0000);
      send_item(CMD_PUSH, 3'd3, 32'sh0);
      send_item(CMD_PUSH, 3'd3, 32'sh5);
      send_item(CMD_PUSH, 3'd1, 32'sh5);
      send_item(CMD_PUSH, 3'd2, 32'sh5);
      send_item(CMD_PUSH, 3'd4, 32'shFFFF_FFFF);
      repeat (8) send_item(CMD_POP, 3'd7, 32'shFFFF_FFFF);
      // lane 6 keeps its value while left out of the scan
      send_item(CMD_PUSH, 3'd6, -32'sd7);
      set_lanes(CFG_W'(3));
      send_item(CMD_PUSH, 3'd3, 32'sh1);
      send_item(CMD_POP, 3'd0, 32'sh0);
      // zero setting behaves as one lane
      set_lanes('0);
      send_item(CMD_PUSH, 3'd1, 32'sh9);
      send_item(CMD_PUSH, 3'd0, 32'sh9);
      // write to an unmapped register changes nothing
      settle();
      write_reg(SPARE_ADDR, CSR_DW'(2));
      send_item(CMD_PUSH, 3'd1, 32'sh3);
      // setting above the lane count behaves as all lanes
      set_lanes(CFG_W'(15));
      repeat (3) send_item(CMD_POP, 3'd2, 32'sh0);

      // random phases
      while (items_sent < ITEM_TARGET - FINAL_ITEMS) begin
         src_idle_pct   = pick_pct();
         sink_stall_pct = pick_pct();
         if (!hold_done && items_sent > 300) begin
            // long result hold-off while pushes are still offered
            set_lanes(CFG_W'(LANES));
            src_idle_pct   = 0;
            sink_stall_pct = 0;
            hold_request   = 1'b1;
            hold_done      = 1'b1;
            merge_phase(40);
         end else if (!fill_done && items_sent > 700) begin
            // one lane filled past its depth, then emptied
            set_lanes(random_setting());
            fill_lane = LANE_W'($urandom_range(0, lanes_now - 1));
            fill_tip  = MIN_VALUE + longint'($urandom_range(0, 1000));
            repeat (LANE_DEPTH + 3) begin
               send_item(CMD_PUSH, fill_lane, DATA_W'(fill_tip));
               fill_tip += longint'($urandom_range(0, 3));
            end
            repeat (LANE_DEPTH + 6) begin
               send_item(CMD_POP, LANE_W'($urandom()), DATA_W'($urandom()));
            end
            fill_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            // unordered noise over every field
            set_lanes(random_setting());
            repeat ($urandom_range(20, 50)) begin
               send_item(1'($urandom()), LANE_W'($urandom()), DATA_W'($urandom()));
            end
         end else begin
            set_lanes(random_setting());
            merge_phase($urandom_range(4, 40));
         end
      end

      // closing stretch with no idling at all
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      while (items_sent < ITEM_TARGET) begin
         set_lanes(random_setting());
         merge_phase(30);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d transfers over %0d lane settings, with a full lane and a long hold-off",
               items_sent, settings_done);
      $display("Seen %0d merged values, %0d empty pops, %0d full drops, %0d rejected lanes",
               merged_count, empty_count, full_count, range_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/kwm_pkg.sv
rtl/core/kwm_ram.sv
rtl/core/kwm_lane_file.sv
rtl/core/k_way_sorted_merge.sv
bench/kwm_merge_checker.sv
bench/k_way_sorted_merge_tb.sv
